/* rtl/assert_macros.svh */
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define STX_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define STX_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/stx_pkg.sv */
// Package with the mixing constants, datapath operation codes and status type.
package stx_pkg;

	localparam logic [63:0] K_LEN_MUL  = 64'h9E3779B185EBCA87;
	localparam logic [63:0] K_B_INIT   = 64'hD6E8FEB86659FD93;
	localparam logic [63:0] K_A_POS    = 64'h00000100000001B3;
	localparam logic [63:0] K_A_MUL    = 64'h94D049BB133111EB;
	localparam logic [63:0] K_B_POS    = 64'hA24BAED4963EE407;
	localparam logic [63:0] K_B_MUL    = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] K_EMIT_POS = 64'h9E3779B97F4A7C15;

	localparam logic CFG_SEED_A = 1'b0;
	localparam logic CFG_SEED_B = 1'b1;

	typedef logic [4:0] op_t;

	localparam op_t OP_NONE        = 5'd0;
	localparam op_t OP_LOAD        = 5'd1;
	localparam op_t OP_ABS_MIX     = 5'd2;
	localparam op_t OP_MUL_A_START = 5'd3;
	localparam op_t OP_MUL_A_WAIT  = 5'd4;
	localparam op_t OP_MUL_B_START = 5'd5;
	localparam op_t OP_MUL_B_WAIT  = 5'd6;
	localparam op_t OP_RD_A        = 5'd7;
	localparam op_t OP_RD_B        = 5'd8;
	localparam op_t OP_RD_C        = 5'd9;
	localparam op_t OP_PACK        = 5'd10;
	localparam op_t OP_EM_MIX_A    = 5'd11;
	localparam op_t OP_EM_MIX_B    = 5'd12;
	localparam op_t OP_MUL_E_START = 5'd13;
	localparam op_t OP_MUL_E_WAIT  = 5'd14;
	localparam op_t OP_MUL_P_START = 5'd15;
	localparam op_t OP_MUL_P_WAIT  = 5'd16;
	localparam op_t OP_EMIT        = 5'd17;

	typedef struct packed {
		logic mul_done;
		logic mul_busy;
		logic last_pos;
		logic out_free;
	} sts_t;

endpackage

/* rtl/stx_if.sv */
// Stream interfaces for salt bytes in and expanded words out.
interface stx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] salt_byte;

	modport source (output valid, output salt_byte, input ready);
	modport sink (input valid, input salt_byte, output ready);
endinterface

interface stx_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] wide_word;
	logic [5:0]  word_index;
	logic        last_word;

	modport source (output valid, output wide_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input wide_word, input word_index, input last_word,
		output ready);
endinterface

/* rtl/stx_mul.sv */
// Iterative 64-bit multiplier giving the low 64 product bits from three 32x32 products.
module stx_mul
	import stx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	input  logic [63:0] y,
	output logic        busy,
	output logic        done,
	output logic [63:0] p
);

	logic        busy_q;
	logic [1:0]  ph_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] mx;
	logic [31:0] my;
	logic [63:0] prod_c;

	always_comb begin
		case (ph_q)
			2'd0: begin
				mx = x_q[31:0];
				my = y_q[31:0];
			end
			2'd1: begin
				mx = x_q[31:0];
				my = y_q[63:32];
			end
			default: begin
				mx = x_q[63:32];
				my = y_q[31:0];
			end
		endcase
	end

	assign prod_c = 64'(mx) * 64'(my);
	assign done   = busy_q && (ph_q == 2'd3);
	assign busy   = busy_q;
	assign p      = acc_q + {prod_q[31:0], 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 2'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			ph_q   <= 2'd0;
		end else if (busy_q) begin
			ph_q <= ph_q + 2'd1;
			if (ph_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			case (ph_q)
				2'd0: begin
					prod_q <= prod_c;
				end
				2'd1: begin
					acc_q  <= prod_q;
					prod_q <= prod_c;
				end
				2'd2: begin
					acc_q  <= acc_q + {prod_q[31:0], 32'd0};
					prod_q <= prod_c;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/stx_datapath.sv */
// Datapath: seeds, byte store, running values, multiplier and output register.
module stx_datapath
	import stx_pkg::*;
#(
	parameter int TABLE_LEN = 64
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         op,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [7:0]  salt_byte,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [63:0] wide_word,
	output logic [5:0]  word_index,
	output logic        last_word,
	output sts_t        sts
);

	localparam int PW = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;
	localparam logic [63:0] LEN_KA = 64'(TABLE_LEN) * K_LEN_MUL;
	localparam int B_INIT = 3 % TABLE_LEN;
	localparam int C_INIT = 5 % TABLE_LEN;
	localparam int B_STEP = 7 % TABLE_LEN;
	localparam int C_STEP = 13 % TABLE_LEN;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] s);
		return (v << s) | (v >> (7'd64 - {1'b0, s}));
	endfunction

	logic [63:0] seed_a_q;
	logic [63:0] seed_b_q;
	logic [63:0] run_a_q;
	logic [63:0] run_b_q;
	logic [63:0] ka_q;
	logic [63:0] kb_q;
	logic [63:0] ke_q;
	logic [7:0]  byte_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] ib_q;
	logic [PW-1:0] ic_q;
	logic [7:0]  byte_store_q [TABLE_LEN];
	logic [7:0]  rd_q;
	logic [PW-1:0] rd_addr;
	logic [7:0]  pk0_q;
	logic [7:0]  pk1_q;
	logic [47:0] pack_q;
	logic [63:0] w_q;
	logic        out_valid_q;
	logic [63:0] out_word_q;
	logic [5:0]  out_index_q;
	logic        out_last_q;

	logic [5:0]  pos6;
	logic        last_pos;
	logic        out_free;
	logic [PW:0] ib_sum;
	logic [PW:0] ic_sum;
	logic [PW-1:0] ib_n;
	logic [PW-1:0] ic_n;
	logic [63:0] pack64;

	logic        mul_start;
	logic [63:0] mul_x;
	logic [63:0] mul_y;
	logic        mul_busy;
	logic        mul_done;
	logic [63:0] mul_p;

	assign pos6     = 6'(pos_q);
	assign last_pos = (pos_q == PW'(TABLE_LEN - 1));
	assign out_free = !out_valid_q || out_ready;
	assign pack64   = {16'd0, pack_q};

	assign ib_sum = {1'b0, ib_q} + (PW + 1)'(B_STEP);
	assign ic_sum = {1'b0, ic_q} + (PW + 1)'(C_STEP);
	assign ib_n   = (ib_sum >= (PW + 1)'(TABLE_LEN)) ?
		PW'(ib_sum - (PW + 1)'(TABLE_LEN)) : PW'(ib_sum);
	assign ic_n   = (ic_sum >= (PW + 1)'(TABLE_LEN)) ?
		PW'(ic_sum - (PW + 1)'(TABLE_LEN)) : PW'(ic_sum);

	always_comb begin
		mul_start = 1'b0;
		mul_x     = run_a_q;
		mul_y     = K_A_MUL;
		case (op)
			OP_MUL_A_START: begin
				mul_start = 1'b1;
			end
			OP_MUL_B_START: begin
				mul_start = 1'b1;
				mul_x     = run_b_q;
				mul_y     = K_B_MUL;
			end
			OP_MUL_E_START: begin
				mul_start = 1'b1;
				mul_x     = run_b_q;
				mul_y     = K_B_INIT;
			end
			OP_MUL_P_START: begin
				mul_start = 1'b1;
				mul_x     = pack64;
				mul_y     = K_LEN_MUL;
			end
			default: begin
			end
		endcase
	end

	stx_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.busy   (mul_busy),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_comb begin
		case (op)
			OP_RD_B: begin
				rd_addr = ib_q;
			end
			OP_RD_C: begin
				rd_addr = ic_q;
			end
			default: begin
				rd_addr = pos_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == OP_LOAD) begin
			byte_store_q[pos_q] <= salt_byte;
		end
		rd_q <= byte_store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q <= 64'd0;
			seed_b_q <= 64'd0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SEED_A) begin
				seed_a_q <= cfg_data;
			end else begin
				seed_b_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (op == OP_MUL_B_WAIT && mul_done) begin
			pos_q <= last_pos ? '0 : pos_q + PW'(1);
		end else if (op == OP_EMIT) begin
			pos_q <= last_pos ? '0 : pos_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				byte_q <= salt_byte;
				if (pos_q == '0) begin
					run_a_q <= seed_a_q ^ LEN_KA;
					run_b_q <= seed_b_q ^ K_B_INIT;
					ka_q    <= K_A_POS;
					kb_q    <= 64'd0;
				end
			end
			OP_ABS_MIX: begin
				run_a_q <= rotl64(run_a_q ^ ({56'd0, byte_q} + ka_q), 6'd11 + pos6);
				run_b_q <= rotl64(run_b_q + ({56'd0, byte_q} ^ kb_q), 6'd19 + pos6 * 6'd3);
			end
			OP_MUL_A_WAIT: begin
				if (mul_done) begin
					run_a_q <= mul_p;
				end
			end
			OP_MUL_B_WAIT: begin
				if (mul_done) begin
					run_b_q <= mul_p;
					ka_q    <= ka_q + K_A_POS;
					kb_q    <= kb_q + K_B_POS;
					if (last_pos) begin
						ib_q <= PW'(B_INIT);
						ic_q <= PW'(C_INIT);
						ke_q <= K_EMIT_POS;
					end
				end
			end
			OP_RD_B: begin
				pk0_q <= rd_q;
			end
			OP_RD_C: begin
				pk1_q <= rd_q;
			end
			OP_PACK: begin
				pack_q <= {rd_q, 16'd0, pk1_q, 8'd0, pk0_q};
			end
			OP_EM_MIX_A: begin
				run_a_q <= rotl64(run_a_q ^ (pack64 + ke_q), 6'd23 + pos6);
			end
			OP_EM_MIX_B: begin
				run_b_q <= run_b_q + rotl64(run_a_q ^ pack64, 6'd31 + pos6 * 6'd5);
			end
			OP_MUL_E_WAIT: begin
				if (mul_done) begin
					run_b_q <= mul_p ^ (mul_p >> 29);
				end
			end
			OP_MUL_P_WAIT: begin
				if (mul_done) begin
					w_q <= run_a_q ^ rotl64(run_b_q, pos6 * 6'd9) ^ mul_p;
				end
			end
			OP_EMIT: begin
				ke_q <= ke_q + K_EMIT_POS;
				ib_q <= ib_n;
				ic_q <= ic_n;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_EMIT) begin
			out_word_q  <= w_q;
			out_index_q <= pos6;
			out_last_q  <= last_pos;
		end
	end

	assign out_valid  = out_valid_q;
	assign wide_word  = out_word_q;
	assign word_index = out_index_q;
	assign last_word  = out_last_q;

	assign sts.mul_done = mul_done;
	assign sts.mul_busy = mul_busy;
	assign sts.last_pos = last_pos;
	assign sts.out_free = out_free;

endmodule

/* rtl/stx_ctrl.sv */
// Controller state machine sequencing byte absorb and the emit walk.
module stx_ctrl
	import stx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	input  sts_t sts,
	output logic byte_ready,
	output op_t  op
);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_ABS_MIX   = 5'd1;
	localparam logic [4:0] S_ABS_MULA  = 5'd2;
	localparam logic [4:0] S_ABS_WAITA = 5'd3;
	localparam logic [4:0] S_ABS_MULB  = 5'd4;
	localparam logic [4:0] S_ABS_WAITB = 5'd5;
	localparam logic [4:0] S_RD_A      = 5'd6;
	localparam logic [4:0] S_RD_B      = 5'd7;
	localparam logic [4:0] S_RD_C      = 5'd8;
	localparam logic [4:0] S_PACK      = 5'd9;
	localparam logic [4:0] S_MIX_A     = 5'd10;
	localparam logic [4:0] S_MIX_B     = 5'd11;
	localparam logic [4:0] S_MUL_E     = 5'd12;
	localparam logic [4:0] S_WAIT_E    = 5'd13;
	localparam logic [4:0] S_MUL_P     = 5'd14;
	localparam logic [4:0] S_WAIT_P    = 5'd15;
	localparam logic [4:0] S_EMIT      = 5'd16;

	logic [4:0] state_q;
	logic [4:0] state_n;

	assign byte_ready = (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		op      = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (byte_valid) begin
					op      = OP_LOAD;
					state_n = S_ABS_MIX;
				end
			end
			S_ABS_MIX: begin
				op      = OP_ABS_MIX;
				state_n = S_ABS_MULA;
			end
			S_ABS_MULA: begin
				op      = OP_MUL_A_START;
				state_n = S_ABS_WAITA;
			end
			S_ABS_WAITA: begin
				op = OP_MUL_A_WAIT;
				if (sts.mul_done) begin
					state_n = S_ABS_MULB;
				end
			end
			S_ABS_MULB: begin
				op      = OP_MUL_B_START;
				state_n = S_ABS_WAITB;
			end
			S_ABS_WAITB: begin
				op = OP_MUL_B_WAIT;
				if (sts.mul_done) begin
					state_n = sts.last_pos ? S_RD_A : S_IDLE;
				end
			end
			S_RD_A: begin
				op      = OP_RD_A;
				state_n = S_RD_B;
			end
			S_RD_B: begin
				op      = OP_RD_B;
				state_n = S_RD_C;
			end
			S_RD_C: begin
				op      = OP_RD_C;
				state_n = S_PACK;
			end
			S_PACK: begin
				op      = OP_PACK;
				state_n = S_MIX_A;
			end
			S_MIX_A: begin
				op      = OP_EM_MIX_A;
				state_n = S_MIX_B;
			end
			S_MIX_B: begin
				op      = OP_EM_MIX_B;
				state_n = S_MUL_E;
			end
			S_MUL_E: begin
				op      = OP_MUL_E_START;
				state_n = S_WAIT_E;
			end
			S_WAIT_E: begin
				op = OP_MUL_E_WAIT;
				if (sts.mul_done) begin
					state_n = S_MUL_P;
				end
			end
			S_MUL_P: begin
				op      = OP_MUL_P_START;
				state_n = S_WAIT_P;
			end
			S_WAIT_P: begin
				op = OP_MUL_P_WAIT;
				if (sts.mul_done) begin
					state_n = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					op      = OP_EMIT;
					state_n = sts.last_pos ? S_IDLE : S_RD_A;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

/* rtl/salt_table_wide_expander_top.sv */
// Top level of the salt table wide expander: controller, datapath and checks.
// Absorb: each byte takes two passes through the multiplier before the next byte is taken.
// Emit: after the last byte, each word takes three byte-store reads and two multiplier passes,
// and the walk waits while the output register still holds a word that was not taken.
// TABLE_LEN words per job.
// Reset clears the seeds, the position counter, the controller and the output valid.
`include "assert_macros.svh"

module salt_table_wide_expander_top
	import stx_pkg::*;
#(
	parameter int TABLE_LEN = 64
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	stx_byte_if.sink    byte_in,
	stx_word_if.source  word_out
);

	op_t  op;
	sts_t sts;
	logic mul_in_wait;
	logic word_taken;

	stx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_in.valid),
		.sts        (sts),
		.byte_ready (byte_in.ready),
		.op         (op)
	);

	stx_datapath #(
		.TABLE_LEN (TABLE_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.salt_byte  (byte_in.salt_byte),
		.out_ready  (word_out.ready),
		.out_valid  (word_out.valid),
		.wide_word  (word_out.wide_word),
		.word_index (word_out.word_index),
		.last_word  (word_out.last_word),
		.sts        (sts)
	);

	assign mul_in_wait = (op == OP_MUL_A_WAIT) || (op == OP_MUL_B_WAIT) ||
		(op == OP_MUL_E_WAIT) || (op == OP_MUL_P_WAIT);
	assign word_taken  = word_out.valid && word_out.ready;

	`STX_ASSERT_IMP(a_done_in_wait, sts.mul_done, mul_in_wait, "multiplier done outside a wait")
	`STX_ASSERT_IMP(a_idle_mul_free, byte_in.ready, !sts.mul_busy, "idle while multiplier busy")
	`STX_ASSERT_IMP(a_walk_not_idle, word_taken && !word_out.last_word, !byte_in.ready, "idle early")
	`STX_ASSERT_NXT(a_load_leaves_idle, op == OP_LOAD, !byte_in.ready, "still idle after a byte")

endmodule

/* sim/salt_table_wide_expander_checker.sv */
// Watches the byte, word and configuration traffic of the expander and checks every word.
`timescale 1ns / 100ps

module salt_table_wide_expander_checker
	import stx_pkg::*;
#(
	parameter int TABLE_LEN = 64
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	stx_byte_if         byte_mon,
	stx_word_if         word_mon,
	output int unsigned fail_count,
	output int unsigned words_pending,
	output int unsigned words_checked
);

	typedef struct packed {
		logic [63:0] wide_word;
		logic [5:0]  word_index;
		logic        last_word;
	} salt_word_t;

	salt_word_t  predicted_words[$];
	logic [63:0] seed_a_copy;
	logic [63:0] seed_b_copy;
	logic [63:0] mix_a;
	logic [63:0] mix_b;
	logic [7:0]  salt_tab[TABLE_LEN];
	int unsigned fill;

	function automatic logic [63:0] rot_left(input logic [63:0] v, input int unsigned s);
		int unsigned k;
		k = s % 64;
		if (k == 0) begin
			return v;
		end
		return (v << k) | (v >> (64 - k));
	endfunction

	// Folds one salt byte into both running values; the last byte of a table
	// also runs the whole expansion and queues one word per position.
	task automatic fold_salt_byte(input logic [7:0] b);
		logic [63:0] pos;
		logic [63:0] pack;
		logic [63:0] w;
		int unsigned ib;
		int unsigned ic;
		salt_word_t  e;
		if (fill == 0) begin
			mix_a = seed_a_copy ^ (64'(TABLE_LEN) * K_LEN_MUL);
			mix_b = seed_b_copy ^ K_B_INIT;
		end
		pos = 64'(fill);
		salt_tab[fill] = b;
		mix_a = mix_a ^ (64'(b) + (pos + 64'd1) * K_A_POS);
		mix_a = rot_left(mix_a, 11 + fill);
		mix_a = mix_a * K_A_MUL;
		mix_b = mix_b + (64'(b) ^ (pos * K_B_POS));
		mix_b = rot_left(mix_b, 19 + fill * 3);
		mix_b = mix_b * K_B_MUL;
		fill++;
		if (fill == TABLE_LEN) begin
			for (int unsigned i = 0; i < TABLE_LEN; i++) begin
				ib = (i * 7 + 3) % TABLE_LEN;
				ic = (i * 13 + 5) % TABLE_LEN;
				pack = 64'(salt_tab[i]) | (64'(salt_tab[ib]) << 16) | (64'(salt_tab[ic]) << 40);
				mix_a = mix_a ^ (pack + 64'(i + 1) * K_EMIT_POS);
				mix_a = rot_left(mix_a, 23 + i);
				mix_b = mix_b + rot_left(mix_a ^ pack, 31 + i * 5);
				mix_b = mix_b * K_B_INIT;
				mix_b = mix_b ^ (mix_b >> 29);
				w = mix_a ^ rot_left(mix_b, i * 9) ^ (pack * K_LEN_MUL);
				e.wide_word = w;
				e.word_index = 6'(i);
				e.last_word = (i == TABLE_LEN - 1);
				predicted_words = {predicted_words, e};
			end
			fill = 0;
		end
	endtask

	task automatic check_word();
		salt_word_t e;
		if (predicted_words.size() == 0) begin
			$error("word %h at index %0d arrived with none predicted",
				word_mon.wide_word, word_mon.word_index);
			fail_count++;
		end else begin
			e = predicted_words.pop_front();
			words_checked++;
			if (word_mon.wide_word !== e.wide_word) begin
				$error("wide_word mismatch: expected %h, actual %h", e.wide_word, word_mon.wide_word);
				fail_count++;
			end
			if (word_mon.word_index !== e.word_index) begin
				$error("word_index mismatch: expected %0d, actual %0d", e.word_index,
					word_mon.word_index);
				fail_count++;
			end
			if (word_mon.last_word !== e.last_word) begin
				$error("last_word mismatch: expected %0b, actual %0b", e.last_word,
					word_mon.last_word);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_copy = '0;
			seed_b_copy = '0;
			fill = 0;
			predicted_words.delete();
			fail_count = 0;
			words_checked = 0;
			words_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SEED_A: seed_a_copy = cfg_data;
					CFG_SEED_B: seed_b_copy = cfg_data;
					default: ;
				endcase
			end
			if (word_mon.valid && word_mon.ready) begin
				check_word();
			end
			if (byte_mon.valid && byte_mon.ready) begin
				fold_salt_byte(byte_mon.salt_byte);
			end
			words_pending = predicted_words.size();
		end
	end

endmodule

/* sim/salt_table_wide_expander_top_test.sv */
// Top of the expander testbench: clock, reset, byte and seed stimulus, output pacing, verdict.
`timescale 1ns / 100ps

module salt_table_wide_expander_top_test;
	import stx_pkg::*;

	localparam int TABLE_LEN    = 64;
	localparam int HOLD_CYCLES  = 600;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 60;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;

	stx_byte_if byte_ch();
	stx_word_if word_ch();

	int unsigned fail_count;
	int unsigned words_pending;
	int unsigned words_checked;
	int unsigned stall_cycles;
	int unsigned hold_seq;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned bytes_sent;
	int unsigned seed_settings;
	bit          quiet;

	salt_table_wide_expander_top #(
		.TABLE_LEN(TABLE_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_in(byte_ch),
		.word_out(word_ch)
	);

	salt_table_wide_expander_checker #(
		.TABLE_LEN(TABLE_LEN)
	) word_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_mon(byte_ch),
		.word_mon(word_ch),
		.fail_count(fail_count),
		.words_pending(words_pending),
		.words_checked(words_checked)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The receiver can be told to hold off for a long stretch so that the
	// block backs up and stops taking salt bytes.
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			word_ch.ready <= 1'b0;
		end else begin
			word_ch.ready <= quiet || ($urandom_range(99) >= 11);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles = 0;
		end else if ((byte_ch.valid && byte_ch.ready) || (word_ch.valid && word_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_salt(input logic [7:0] b);
		while (!quiet && $urandom_range(99) < 11) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.salt_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready) begin
			@(posedge clk);
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_salt(input int unsigned n);
		for (int unsigned k = 0; k < n; k++) begin
			send_salt(8'($urandom_range(255)));
		end
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		while (words_pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_seeds(input logic [63:0] a, input logic [63:0] b);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SEED_A;
		cfg_data <= a;
		@(negedge clk);
		cfg_index <= CFG_SEED_B;
		cfg_data <= b;
		@(negedge clk);
		cfg_we <= 1'b0;
		seed_settings++;
	endtask

	initial begin
		logic [7:0] walk;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SEED_A;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.salt_byte = '0;
		quiet = 1'b0;
		hold_seq = 0;
		hold_seen = 0;
		hold_left = 0;
		bytes_sent = 0;
		seed_settings = 1;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First table runs on the seeds left by reset and opens with fixed patterns.
		send_salt(8'h00);
		send_salt(8'hFF);
		send_salt(8'h00);
		send_salt(8'hFF);
		for (int k = 0; k < 8; k++) begin
			walk = 8'h01 << k;
			send_salt(walk);
		end
		for (int k = 0; k < 8; k++) begin
			walk = ~(8'h01 << k);
			send_salt(walk);
		end
		send_salt(8'h55);
		send_salt(8'hAA);
		send_random_salt(TABLE_LEN - 22);
		wait_drained();

		// A seed change in the middle of a table must only affect the next table.
		set_seeds('1, '1);
		send_random_salt(30);
		byte_ch.valid <= 1'b0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		set_seeds('0, '1);
		send_random_salt(TABLE_LEN - 30);

		// The next table is offered at once while the receiver is held off.
		hold_seq++;
		send_random_salt(TABLE_LEN);
		wait_drained();

		set_seeds('1, '0);
		quiet = 1'b1;
		send_random_salt(TABLE_LEN);
		wait_drained();
		quiet = 1'b0;

		for (int k = 0; k < 3; k++) begin
			set_seeds({$urandom, $urandom}, {$urandom, $urandom});
			send_random_salt(TABLE_LEN);
			if (k != 2) begin
				wait_drained();
			end
		end
		wait_drained();

		if (words_pending != 0) begin
			$error("%0d predicted words never arrived", words_pending);
		end
		$display("Sent %0d salt bytes as %0d tables under %0d seed settings.",
			bytes_sent, bytes_sent / TABLE_LEN, seed_settings);
		$display("Compared %0d expanded words against the prediction.", words_checked);
		if (fail_count == 0 && words_pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
